// ===== rtl/core/acs_pkg.sv =====
// Shared types, constants and presentation-form lookups for the contextual shaper.
// No dependencies; used by every module of the shaper.
package acs_pkg;

	localparam int CodeW = 21;
	localparam int FormW = 16;
	localparam int PosW  = 16;
	localparam logic [CodeW-1:0] LamCode = 21'h000644;
	localparam logic [PosW-1:0]  PosMax  = 16'hFFFF;

	// One classified cell as it travels from front to back
	typedef struct packed {
		logic [CodeW-1:0] code;
		logic [FormW-1:0] f_iso;
		logic [FormW-1:0] f_rt;
		logic [FormW-1:0] f_lf;
		logic [FormW-1:0] f_both;
		logic             in_tab;
		logic             is_lig;
		logic             has_left;
		logic             rj_src;
		logic             has_comb;
		logic             line_end;
	} cell_t;

	// Forms of a letter: {isolated, right, left, both}; zero when not a letter
	function automatic logic [4*FormW-1:0] form_lookup(input logic [FormW-1:0] c);
		logic [4*FormW-1:0] r;
		r = '0;
		unique case (c)
			16'h0621: r = {16'hFE80, 16'h0000, 16'h0000, 16'h0000};
			16'h0622: r = {16'hFE81, 16'hFE82, 16'h0000, 16'h0000};
			16'h0623: r = {16'hFE83, 16'hFE84, 16'h0000, 16'h0000};
			16'h0624: r = {16'hFE85, 16'hFE86, 16'h0000, 16'h0000};
			16'h0625: r = {16'hFE87, 16'hFE88, 16'h0000, 16'h0000};
			16'h0626: r = {16'hFE89, 16'hFE8A, 16'hFE8B, 16'hFE8C};
			16'h0627: r = {16'hFE8D, 16'hFE8E, 16'h0000, 16'h0000};
			16'h0628: r = {16'hFE8F, 16'hFE90, 16'hFE91, 16'hFE92};
			16'h0629: r = {16'hFE93, 16'hFE94, 16'h0000, 16'h0000};
			16'h062A: r = {16'hFE95, 16'hFE96, 16'hFE97, 16'hFE98};
			16'h062B: r = {16'hFE99, 16'hFE9A, 16'hFE9B, 16'hFE9C};
			16'h062C: r = {16'hFE9D, 16'hFE9E, 16'hFE9F, 16'hFEA0};
			16'h062D: r = {16'hFEA1, 16'hFEA2, 16'hFEA3, 16'hFEA4};
			16'h062E: r = {16'hFEA5, 16'hFEA6, 16'hFEA7, 16'hFEA8};
			16'h062F: r = {16'hFEA9, 16'hFEAA, 16'h0000, 16'h0000};
			16'h0630: r = {16'hFEAB, 16'hFEAC, 16'h0000, 16'h0000};
			16'h0631: r = {16'hFEAD, 16'hFEAE, 16'h0000, 16'h0000};
			16'h0632: r = {16'hFEAF, 16'hFEB0, 16'h0000, 16'h0000};
			16'h0633: r = {16'hFEB1, 16'hFEB2, 16'hFEB3, 16'hFEB4};
			16'h0634: r = {16'hFEB5, 16'hFEB6, 16'hFEB7, 16'hFEB8};
			16'h0635: r = {16'hFEB9, 16'hFEBA, 16'hFEBB, 16'hFEBC};
			16'h0636: r = {16'hFEBD, 16'hFEBE, 16'hFEBF, 16'hFEC0};
			16'h0637: r = {16'hFEC1, 16'hFEC2, 16'hFEC3, 16'hFEC4};
			16'h0638: r = {16'hFEC5, 16'hFEC6, 16'hFEC7, 16'hFEC8};
			16'h0639: r = {16'hFEC9, 16'hFECA, 16'hFECB, 16'hFECC};
			16'h063A: r = {16'hFECD, 16'hFECE, 16'hFECF, 16'hFED0};
			16'h0640: r = {16'h0640, 16'h0640, 16'h0640, 16'h0640};
			16'h0641: r = {16'hFED1, 16'hFED2, 16'hFED3, 16'hFED4};
			16'h0642: r = {16'hFED5, 16'hFED6, 16'hFED7, 16'hFED8};
			16'h0643: r = {16'hFED9, 16'hFEDA, 16'hFEDB, 16'hFEDC};
			16'h0644: r = {16'hFEDD, 16'hFEDE, 16'hFEDF, 16'hFEE0};
			16'h0645: r = {16'hFEE1, 16'hFEE2, 16'hFEE3, 16'hFEE4};
			16'h0646: r = {16'hFEE5, 16'hFEE6, 16'hFEE7, 16'hFEE8};
			16'h0647: r = {16'hFEE9, 16'hFEEA, 16'hFEEB, 16'hFEEC};
			16'h0648: r = {16'hFEED, 16'hFEEE, 16'h0000, 16'h0000};
			16'h0649: r = {16'hFEEF, 16'hFEF0, 16'hFBE8, 16'hFBE9};
			16'h064A: r = {16'hFEF1, 16'hFEF2, 16'hFEF3, 16'hFEF4};
			16'h0671: r = {16'hFB50, 16'hFB51, 16'h0000, 16'h0000};
			16'h0679: r = {16'hFB66, 16'hFB67, 16'hFB68, 16'hFB69};
			16'h067A: r = {16'hFB5E, 16'hFB5F, 16'hFB60, 16'hFB61};
			16'h067B: r = {16'hFB52, 16'hFB53, 16'hFB54, 16'hFB55};
			16'h067E: r = {16'hFB56, 16'hFB57, 16'hFB58, 16'hFB59};
			16'h067F: r = {16'hFB62, 16'hFB63, 16'hFB64, 16'hFB65};
			16'h0680: r = {16'hFB5A, 16'hFB5B, 16'hFB5C, 16'hFB5D};
			16'h0683: r = {16'hFB76, 16'hFB77, 16'hFB78, 16'hFB79};
			16'h0684: r = {16'hFB72, 16'hFB73, 16'hFB74, 16'hFB75};
			16'h0686: r = {16'hFB7A, 16'hFB7B, 16'hFB7C, 16'hFB7D};
			16'h0687: r = {16'hFB7E, 16'hFB7F, 16'hFB80, 16'hFB81};
			16'h0688: r = {16'hFB88, 16'hFB89, 16'h0000, 16'h0000};
			16'h068C: r = {16'hFB84, 16'hFB85, 16'h0000, 16'h0000};
			16'h068D: r = {16'hFB82, 16'hFB83, 16'h0000, 16'h0000};
			16'h068E: r = {16'hFB86, 16'hFB87, 16'h0000, 16'h0000};
			16'h0691: r = {16'hFB8C, 16'hFB8D, 16'h0000, 16'h0000};
			16'h0698: r = {16'hFB8A, 16'hFB8B, 16'h0000, 16'h0000};
			16'h06A4: r = {16'hFB6A, 16'hFB6B, 16'hFB6C, 16'hFB6D};
			16'h06A6: r = {16'hFB6E, 16'hFB6F, 16'hFB70, 16'hFB71};
			16'h06A9: r = {16'hFB8E, 16'hFB8F, 16'hFB90, 16'hFB91};
			16'h06AD: r = {16'hFBD3, 16'hFBD4, 16'hFBD5, 16'hFBD6};
			16'h06AF: r = {16'hFB92, 16'hFB93, 16'hFB94, 16'hFB95};
			16'h06B1: r = {16'hFB9A, 16'hFB9B, 16'hFB9C, 16'hFB9D};
			16'h06B3: r = {16'hFB96, 16'hFB97, 16'hFB98, 16'hFB99};
			16'h06BA: r = {16'hFB9E, 16'hFB9F, 16'h0000, 16'h0000};
			16'h06BB: r = {16'hFBA0, 16'hFBA1, 16'hFBA2, 16'hFBA3};
			16'h06BE: r = {16'hFBAA, 16'hFBAB, 16'hFBAC, 16'hFBAD};
			16'h06C0: r = {16'hFBA4, 16'hFBA5, 16'h0000, 16'h0000};
			16'h06C1: r = {16'hFBA6, 16'hFBA7, 16'hFBA8, 16'hFBA9};
			16'h06C5: r = {16'hFBE0, 16'hFBE1, 16'h0000, 16'h0000};
			16'h06C6: r = {16'hFBD9, 16'hFBDA, 16'h0000, 16'h0000};
			16'h06C7: r = {16'hFBD7, 16'hFBD8, 16'h0000, 16'h0000};
			16'h06C8: r = {16'hFBDB, 16'hFBDC, 16'h0000, 16'h0000};
			16'h06C9: r = {16'hFBE2, 16'hFBE3, 16'h0000, 16'h0000};
			16'h06CB: r = {16'hFBDE, 16'hFBDF, 16'h0000, 16'h0000};
			16'h06CC: r = {16'hFBFC, 16'hFBFD, 16'hFBFE, 16'hFBFF};
			16'h06D0: r = {16'hFBE4, 16'hFBE5, 16'hFBE6, 16'hFBE7};
			16'h06D2: r = {16'hFBAE, 16'hFBAF, 16'h0000, 16'h0000};
			16'h06D3: r = {16'hFBB0, 16'hFBB1, 16'h0000, 16'h0000};
			default:  r = '0;
		endcase
		return r;
	endfunction

	// Lam-alef ligature forms by alef: {isolated, right}; zero when no ligature
	function automatic logic [2*FormW-1:0] lig_lookup(input logic [FormW-1:0] m);
		logic [2*FormW-1:0] r;
		r = '0;
		unique case (m)
			16'h0622: r = {16'hFEF5, 16'hFEF6};
			16'h0623: r = {16'hFEF7, 16'hFEF8};
			16'h0625: r = {16'hFEF9, 16'hFEFA};
			16'h0627: r = {16'hFEFB, 16'hFEFC};
			default:  r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/acs_front.sv =====
// Front part of the shaper: looks up each incoming cell in the form tables.
// Depends on acs_pkg.
module acs_front (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [20:0]          char_code,
	input  logic                 is_unicode,
	input  logic                 has_combining,
	input  logic [20:0]          mark_code,
	input  logic                 mark_is_unicode,
	input  logic                 line_end,
	output logic                 cell_valid,
	input  logic                 cell_ready,
	output acs_pkg::cell_t       cls_cell
);
	import acs_pkg::*;

	logic [4*FormW-1:0] forms;
	logic [2*FormW-1:0] ligs;
	logic               tab_hit;
	logic               lig_hit;

	// Look up letter forms and lam-alef ligature
	always_comb begin
		forms   = form_lookup(char_code[FormW-1:0]);
		ligs    = lig_lookup(mark_code[FormW-1:0]);
		tab_hit = is_unicode && (char_code[CodeW-1:FormW] == '0) &&
			(forms[4*FormW-1:3*FormW] != '0);
		lig_hit = is_unicode && has_combining && mark_is_unicode &&
			(char_code == LamCode) && (mark_code[CodeW-1:FormW] == '0) &&
			(ligs != '0);
	end

	// Build the classified cell
	always_comb begin
		cls_cell.code     = char_code;
		cls_cell.in_tab   = tab_hit;
		cls_cell.is_lig   = lig_hit;
		cls_cell.has_comb = has_combining;
		cls_cell.line_end = line_end;
		cls_cell.f_lf     = forms[2*FormW-1:FormW];
		cls_cell.f_both   = forms[FormW-1:0];
		cls_cell.has_left = tab_hit && (forms[2*FormW-1:FormW] != '0);
		cls_cell.rj_src   = tab_hit && (forms[3*FormW-1:2*FormW] != '0);
		if (lig_hit) begin
			cls_cell.f_iso = ligs[2*FormW-1:FormW];
			cls_cell.f_rt  = ligs[FormW-1:0];
		end else begin
			cls_cell.f_iso = forms[4*FormW-1:3*FormW];
			cls_cell.f_rt  = forms[3*FormW-1:2*FormW];
		end
	end

	assign cell_valid = in_valid;
	assign in_ready   = cell_ready;

endmodule

// ===== rtl/core/acs_queue.sv =====
// Short queue of classified cells between front and back.
// Depends on acs_pkg.
module acs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  acs_pkg::cell_t wr_cell,
	output logic           rd_valid,
	input  logic           rd_ready,
	output acs_pkg::cell_t rd_cell
);
	import acs_pkg::*;

	cell_t      mem_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_cell  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_cell;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 2'd1;
			if (pop)  rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

endmodule

// ===== rtl/core/acs_back.sv =====
// Back part of the shaper: look-ahead window, form selection and output register.
// Depends on acs_pkg.
module acs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    line_capacity,
	input  logic           cell_valid,
	output logic           cell_ready,
	input  acs_pkg::cell_t in_cell,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [20:0]    shaped_code,
	output logic           marks_dropped,
	output logic           last_of_line
);
	import acs_pkg::*;

	cell_t            win_q [3];
	logic [1:0]       cnt_q;
	logic             drain_q;
	logic             left_q;
	logic [PosW-1:0]  pos_q;
	logic             ov_q;
	logic [CodeW-1:0] code_q;
	logic             drop_q;
	logic             last_q;

	logic             out_free;
	logic             pop;
	logic             emit;
	logic             emit_last;
	cell_t            c0;
	cell_t            c1;
	logic             n1_ok;
	logic             rj;
	logic [CodeW-1:0] sel_code;
	logic             sel_drop;

	assign out_free   = !ov_q || out_ready;
	assign cell_ready = out_free && !drain_q;
	assign pop        = cell_valid && cell_ready;
	assign c0         = win_q[0];
	assign c1         = win_q[1];

	// Decide whether the oldest held cell leaves this cycle
	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		n1_ok     = 1'b0;
		if (out_free && drain_q) begin
			emit      = 1'b1;
			emit_last = (cnt_q == 2'd1);
			n1_ok     = (cnt_q != 2'd1);
		end else if (pop && !in_cell.line_end && cnt_q == 2'd2) begin
			emit  = 1'b1;
			n1_ok = 1'b1;
		end
	end

	// Select the presentation form of the oldest cell
	always_comb begin
		rj       = n1_ok && c1.has_left && !c1.is_lig;
		sel_drop = c0.is_lig;
		sel_code = c0.code;
		if (c0.is_lig) begin
			if (n1_ok && !c1.has_comb && c1.has_left)
				sel_code = {5'd0, c0.f_rt};
			else
				sel_code = {5'd0, c0.f_iso};
		end else if (c0.in_tab) begin
			if (left_q) begin
				if (rj) begin
					priority if (c0.f_both != '0) sel_code = {5'd0, c0.f_both};
					else if (c0.f_lf != '0)       sel_code = {5'd0, c0.f_lf};
					else if (c0.f_rt != '0)       sel_code = {5'd0, c0.f_rt};
					else                          sel_code = {5'd0, c0.f_iso};
				end else if (c0.f_lf != '0) begin
					sel_code = {5'd0, c0.f_lf};
				end else begin
					sel_code = {5'd0, c0.f_iso};
				end
			end else if (rj && c0.f_rt != '0) begin
				sel_code = {5'd0, c0.f_rt};
			end else begin
				sel_code = {5'd0, c0.f_iso};
			end
		end
	end

	// Hold cells in the window, shift on emit
	always_ff @(posedge clk) begin
		if (emit) begin
			win_q[0] <= win_q[1];
			win_q[1] <= pop ? in_cell : win_q[2];
		end else if (pop) begin
			win_q[cnt_q] <= in_cell;
		end
	end

	// Track count, drain, left join, position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			drain_q <= 1'b0;
			left_q  <= 1'b0;
			pos_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (emit) ov_q <= (pos_q < line_capacity);
			else if (out_ready) ov_q <= 1'b0;
			if (pop && in_cell.line_end) drain_q <= 1'b1;
			else if (emit_last) drain_q <= 1'b0;
			if (emit) begin
				if (emit_last) begin
					left_q <= 1'b0;
					pos_q  <= '0;
				end else begin
					left_q <= c0.rj_src;
					if (pos_q != PosMax) pos_q <= pos_q + 16'd1;
				end
				if (drain_q) cnt_q <= cnt_q - 2'd1;
			end else if (pop) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			code_q <= sel_code;
			drop_q <= sel_drop;
			last_q <= emit_last;
		end
	end

	assign out_valid     = ov_q;
	assign shaped_code   = code_q;
	assign marks_dropped = drop_q;
	assign last_of_line  = last_q;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd3 |-> drain_q)
		else $error("window over-full");
	a_drain_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> cnt_q != 2'd0)
		else $error("drain with empty window");
	a_no_pop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !drain_q)
		else $error("transaction taken during drain");
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> pos_q == '0 && !left_q)
		else $error("line state not cleared");
`endif

endmodule

// ===== rtl/core/arabic_contextual_shaper_unit.sv =====
// Top level of the Arabic contextual shaper: front classifier, queue, back window.
// Depends on acs_pkg, acs_front, acs_queue, acs_back.
//
// Channel  | Dir | Contents
// s_axis   | in  | tdata: char_code, has_combining, mark_code; tuser: is_unicode,
//          |     |   mark_is_unicode; tlast: line_end
// m_axis   | out | tdata: shaped_code; tuser: marks_dropped; tlast: last_of_line
// cfg      | in  | line_capacity written when cfg_we is high
//
// One cell per cycle is taken unless the queue is full; a result leaves two cells later
// or at line end. Line end flushes up to three results through the output register, one
// per cycle while the output is not stalled; the back window takes no new cell meanwhile.
// The four-entry queue lets the front keep taking cells while the output stalls.
// Reset clears the window, queue, line position and output valid.
module arabic_contextual_shaper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [20:0] char_code, [21] has_combining, [42:22] mark_code
	input  logic [1:0]  s_axis_tuser,  // [0] is_unicode, [1] mark_is_unicode
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [20:0] shaped_code
	output logic [0:0]  m_axis_tuser,  // [0] marks_dropped
	output logic        m_axis_tlast
);
	import acs_pkg::*;

	logic [15:0] cap_q;
	logic        f_valid;
	logic        f_ready;
	cell_t       f_cell;
	logic        q_valid;
	logic        q_ready;
	cell_t       q_cell;
	logic [20:0] code;

	// Hold line capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= 16'hFFFF;
		else if (cfg_we) cap_q <= cfg_wdata;
	end

	acs_front u_front (
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.char_code       (s_axis_tdata[20:0]),
		.is_unicode      (s_axis_tuser[0]),
		.has_combining   (s_axis_tdata[21]),
		.mark_code       (s_axis_tdata[42:22]),
		.mark_is_unicode (s_axis_tuser[1]),
		.line_end        (s_axis_tlast),
		.cell_valid      (f_valid),
		.cell_ready      (f_ready),
		.cls_cell        (f_cell)
	);

	acs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_cell  (f_cell),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_cell  (q_cell)
	);

	acs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_capacity (cap_q),
		.cell_valid    (q_valid),
		.cell_ready    (q_ready),
		.in_cell       (q_cell),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.shaped_code   (code),
		.marks_dropped (m_axis_tuser[0]),
		.last_of_line  (m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, code};

endmodule
